// File: rtl/core/cbad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types and constants for the CPU bus address decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

    localparam int RAM_BYTES     = 2048;
    localparam int ROM_MAX_BYTES = 32768;
    localparam int RAM_AW        = $clog2(RAM_BYTES);
    localparam int ROM_AW        = $clog2(ROM_MAX_BYTES);

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int INDEX_W = 15;
    localparam int CFG_W   = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 4;

    localparam logic [ADDR_W-1:0] RAM_MASK        = 16'h07FF;
    localparam logic [ADDR_W-1:0] RAM_END         = 16'h2000;
    localparam logic [ADDR_W-1:0] PPU_END         = 16'h4000;
    localparam logic [ADDR_W-1:0] PPU_MASK        = 16'h2007;
    localparam logic [ADDR_W-1:0] APU_LAST        = 16'h4013;
    localparam logic [ADDR_W-1:0] DMA_ADDR        = 16'h4014;
    localparam logic [ADDR_W-1:0] APU_STATUS      = 16'h4015;
    localparam logic [ADDR_W-1:0] PAD0_ADDR       = 16'h4016;
    localparam logic [ADDR_W-1:0] PAD1_ADDR       = 16'h4017;
    localparam logic [ADDR_W-1:0] ROM_BASE        = 16'h8000;
    localparam logic [ADDR_W-1:0] ROM_MIRROR_SIZE = 16'd16384;
    localparam logic [ADDR_W-1:0] ROM_MIRROR_MASK = 16'h3FFF;
    localparam logic [ADDR_W-1:0] ROM_LIMIT       = ADDR_W'(ROM_MAX_BYTES);
    localparam logic [ADDR_W-1:0] PAD0_PORT       = 16'd0;
    localparam logic [ADDR_W-1:0] PAD1_PORT       = 16'd1;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_RAM  = 3'd1,
        TGT_ROM  = 3'd2,
        TGT_PPU  = 3'd3,
        TGT_APU  = 3'd4,
        TGT_PAD  = 3'd5,
        TGT_DMA  = 3'd6
    } t_target;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_RAM  = 2'd1,
        SEL_ROM  = 2'd2
    } t_sel;

    typedef struct packed {
        logic              ram_we;
        logic              ram_re;
        logic [RAM_AW-1:0] ram_addr;
        logic              rom_we;
        logic              rom_re;
        logic [ROM_AW-1:0] rom_addr;
        t_sel              sel;
        t_target           target;
        logic [ADDR_W-1:0] dev_addr;
        logic [DATA_W-1:0] dev_data;
        logic              dev_wr;
    } t_dec;

    typedef struct packed {
        t_sel              sel;
        t_target           target;
        logic [ADDR_W-1:0] dev_addr;
        logic [DATA_W-1:0] dev_data;
        logic              dev_wr;
    } t_res;

endpackage
`default_nettype wire

// File: rtl/core/cpu_bus_address_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder_top
// CPU bus decoder with mirrored work RAM and loadable program ROM.
//
//  Group   Dir  Signals                         Contents
//  s       in   i_s_tvalid/o_s_tready/tdata/tuser  bus access or ROM load
//  m       out  o_m_tvalid/i_m_tready/tdata/tuser  decode result
//  cfg     in   i_cfg_we/i_cfg_wdata               program ROM size
//
//  One transaction per cycle sustained while the output is not stalled; the
//  result passes through the synchronous RAM/ROM read, then the output register.
//  After reset the work RAM is zeroed one entry a cycle, all 2048 entries,
//  with o_s_tready low. Configuration writes are taken throughout.
//  A stalled output holds the read stage; input stops once both are full.
// ----------------------------------------------------------------------------
module cpu_bus_address_decoder_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [15:0] address, [23:16] data, [38:24] rom_load_index
    input  wire logic [cbad_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] action
    input  wire logic [cbad_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [7:0] read_data, [23:8] device_address, [31:24] device_data
    output logic      [cbad_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [2:0] target, [3] device_write
    output logic      [cbad_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    input  wire logic                             i_cfg_we,
    input  wire logic [cbad_pkg::CFG_W-1:0]       i_cfg_wdata
);

    logic [cbad_pkg::CFG_W-1:0]  r_prg_bytes;
    logic                        r_clearing;
    logic [cbad_pkg::RAM_AW-1:0] r_clr_addr;
    logic                        r_s1_valid;
    logic                        n_s1_valid;
    cbad_pkg::t_res              r_s1;
    logic                        r_o_valid;
    logic [cbad_pkg::DATA_W-1:0] r_o_rdata;
    cbad_pkg::t_res              r_o;

    cbad_pkg::t_dec              w_dec;
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_ram_we;
    logic                        w_ram_re;
    logic [cbad_pkg::RAM_AW-1:0] w_ram_waddr;
    logic [cbad_pkg::DATA_W-1:0] w_ram_wdata;
    logic [cbad_pkg::DATA_W-1:0] w_ram_rdata;
    logic [cbad_pkg::DATA_W-1:0] w_rom_rdata;
    logic [cbad_pkg::DATA_W-1:0] w_rdata;

    cbad_decode u_decode (
        .i_action    (cbad_pkg::t_action'(i_s_tuser[1:0])),
        .i_address   (i_s_tdata[15:0]),
        .i_data      (i_s_tdata[23:16]),
        .i_index     (i_s_tdata[38:24]),
        .i_prg_bytes (r_prg_bytes),
        .o_dec       (w_dec)
    );

    assign w_out_free = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_clearing && (!r_s1_valid || w_out_free);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_ram_we    = r_clearing || (w_accept && w_dec.ram_we);
    assign w_ram_re    = w_accept && w_dec.ram_re;
    assign w_ram_waddr = r_clearing ? r_clr_addr : w_dec.ram_addr;
    assign w_ram_wdata = r_clearing ? '0 : i_s_tdata[23:16];

    cbad_ram #(
        .WIDTH (cbad_pkg::DATA_W),
        .DEPTH (cbad_pkg::RAM_BYTES)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_dec.ram_addr),
        .o_rdata (w_ram_rdata)
    );

    cbad_ram #(
        .WIDTH (cbad_pkg::DATA_W),
        .DEPTH (cbad_pkg::ROM_MAX_BYTES)
    ) u_prg_rom (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_dec.rom_we),
        .i_waddr (w_dec.rom_addr),
        .i_wdata (i_s_tdata[23:16]),
        .i_re    (w_accept && w_dec.rom_re),
        .i_raddr (w_dec.rom_addr),
        .o_rdata (w_rom_rdata)
    );

    always_comb begin
        unique case (r_s1.sel)
            cbad_pkg::SEL_RAM: w_rdata = w_ram_rdata;
            cbad_pkg::SEL_ROM: w_rdata = w_rom_rdata;
            default:           w_rdata = '0;
        endcase
    end

    always_comb begin
        priority if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_out_free) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bytes <= '0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prg_bytes <= i_cfg_wdata;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + cbad_pkg::RAM_AW'(1);
                if (r_clr_addr == cbad_pkg::RAM_AW'(cbad_pkg::RAM_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid <= n_s1_valid;
            if (w_out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.sel      <= w_dec.sel;
            r_s1.target   <= w_dec.target;
            r_s1.dev_addr <= w_dec.dev_addr;
            r_s1.dev_data <= w_dec.dev_data;
            r_s1.dev_wr   <= w_dec.dev_wr;
        end
        if (w_out_free && r_s1_valid) begin
            r_o       <= r_s1;
            r_o_rdata <= w_rdata;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o.dev_data, r_o.dev_addr, r_o_rdata};
    assign o_m_tuser  = {r_o.dev_wr, r_o.target};

    a_no_accept_while_clearing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_s_tready
    ) else $error("transaction accepted during RAM clear");

    a_clear_after_reset : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_clearing && (r_clr_addr == '0))
    ) else $error("RAM clear did not start after reset");

    a_s1_holds_on_stall : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_out_free) |=> (r_s1_valid && $stable(r_s1))
    ) else $error("read stage lost while output stalled");

    a_ram_port_exclusive : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_re && r_clearing)
    ) else $error("RAM read issued during clear");

    a_single_rom_access : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(w_dec.rom_we && w_dec.rom_re)
    ) else $error("ROM load and read decoded together");

endmodule
`default_nettype wire

// File: rtl/core/cbad_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbad_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/core/cbad_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbad_decode
// Address map: picks the target, memory access and forwarded fields.
// ----------------------------------------------------------------------------
module cbad_decode (
    input  wire cbad_pkg::t_action                i_action,
    input  wire logic [cbad_pkg::ADDR_W-1:0]      i_address,
    input  wire logic [cbad_pkg::DATA_W-1:0]      i_data,
    input  wire logic [cbad_pkg::INDEX_W-1:0]     i_index,
    input  wire logic [cbad_pkg::CFG_W-1:0]       i_prg_bytes,
    output cbad_pkg::t_dec                        o_dec
);

    logic [cbad_pkg::ADDR_W-1:0] w_ram_off;
    logic [cbad_pkg::ADDR_W-1:0] w_rom_off;
    logic                        w_rom_hit;
    logic                        w_load_ok;

    always_comb begin
        w_ram_off = i_address & cbad_pkg::RAM_MASK;
        w_rom_off = i_address - cbad_pkg::ROM_BASE;
        if (i_prg_bytes == cbad_pkg::ROM_MIRROR_SIZE) begin
            w_rom_off = w_rom_off & cbad_pkg::ROM_MIRROR_MASK;
        end
        w_rom_hit = (i_prg_bytes != '0) && (w_rom_off < i_prg_bytes)
                    && (w_rom_off < cbad_pkg::ROM_LIMIT);
        w_load_ok = {1'b0, i_index} < cbad_pkg::ROM_LIMIT;
    end

    always_comb begin
        o_dec          = '0;
        o_dec.sel      = cbad_pkg::SEL_ZERO;
        o_dec.target   = cbad_pkg::TGT_NONE;
        o_dec.ram_addr = w_ram_off[cbad_pkg::RAM_AW-1:0];
        o_dec.rom_addr = w_rom_off[cbad_pkg::ROM_AW-1:0];
        unique case (i_action)
            cbad_pkg::ACT_READ: begin
                priority if (i_address < cbad_pkg::RAM_END) begin
                    o_dec.target = cbad_pkg::TGT_RAM;
                    o_dec.sel    = cbad_pkg::SEL_RAM;
                    o_dec.ram_re = 1'b1;
                end else if (i_address < cbad_pkg::PPU_END) begin
                    o_dec.target   = cbad_pkg::TGT_PPU;
                    o_dec.dev_addr = i_address & cbad_pkg::PPU_MASK;
                end else if (i_address == cbad_pkg::PAD0_ADDR) begin
                    o_dec.target   = cbad_pkg::TGT_PAD;
                    o_dec.dev_addr = cbad_pkg::PAD0_PORT;
                end else if (i_address == cbad_pkg::PAD1_ADDR) begin
                    o_dec.target   = cbad_pkg::TGT_PAD;
                    o_dec.dev_addr = cbad_pkg::PAD1_PORT;
                end else if (i_address == cbad_pkg::APU_STATUS) begin
                    o_dec.target   = cbad_pkg::TGT_APU;
                    o_dec.dev_addr = i_address;
                end else if ((i_address >= cbad_pkg::ROM_BASE) && w_rom_hit) begin
                    o_dec.target = cbad_pkg::TGT_ROM;
                    o_dec.sel    = cbad_pkg::SEL_ROM;
                    o_dec.rom_re = 1'b1;
                end else begin
                    o_dec.target = cbad_pkg::TGT_NONE;
                end
            end
            cbad_pkg::ACT_WRITE: begin
                priority if (i_address < cbad_pkg::RAM_END) begin
                    o_dec.target = cbad_pkg::TGT_RAM;
                    o_dec.ram_we = 1'b1;
                end else if (i_address < cbad_pkg::PPU_END) begin
                    o_dec.target   = cbad_pkg::TGT_PPU;
                    o_dec.dev_addr = i_address & cbad_pkg::PPU_MASK;
                    o_dec.dev_data = i_data;
                    o_dec.dev_wr   = 1'b1;
                end else if (i_address == cbad_pkg::DMA_ADDR) begin
                    o_dec.target   = cbad_pkg::TGT_DMA;
                    o_dec.dev_addr = i_address;
                    o_dec.dev_data = i_data;
                    o_dec.dev_wr   = 1'b1;
                end else if (i_address == cbad_pkg::PAD0_ADDR) begin
                    o_dec.target   = cbad_pkg::TGT_PAD;
                    o_dec.dev_addr = cbad_pkg::PAD0_PORT;
                    o_dec.dev_data = i_data;
                    o_dec.dev_wr   = 1'b1;
                end else if ((i_address <= cbad_pkg::APU_LAST)
                             || (i_address == cbad_pkg::APU_STATUS)
                             || (i_address == cbad_pkg::PAD1_ADDR)) begin
                    o_dec.target   = cbad_pkg::TGT_APU;
                    o_dec.dev_addr = i_address;
                    o_dec.dev_data = i_data;
                    o_dec.dev_wr   = 1'b1;
                end else begin
                    o_dec.target = cbad_pkg::TGT_NONE;
                end
            end
            cbad_pkg::ACT_LOAD: begin
                o_dec.rom_we   = w_load_ok;
                o_dec.rom_addr = i_index[cbad_pkg::ROM_AW-1:0];
            end
            cbad_pkg::ACT_NONE: begin
                o_dec.target = cbad_pkg::TGT_NONE;
            end
            default: begin
                o_dec.target = cbad_pkg::TGT_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams CPU bus reads, writes and program ROM loads into the address
// decoder, with random gaps on the input and random stalls on the output.
// Every transaction is decoded by a local model of the memory map (mirrored
// work RAM, size-checked ROM, forwarded device registers) and each result is
// compared field by field against the oldest pending prediction. The ROM size
// register is stepped through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import cbad_pkg::*;

    typedef struct packed {
        t_action             action;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   data;
        logic [INDEX_W-1:0]  load_index;
    } bus_access_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        t_target             target;
        logic [ADDR_W-1:0]   dev_addr;
        logic [DATA_W-1:0]   dev_data;
        logic                dev_wr;
    } bus_result_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    cpu_bus_address_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    logic [DATA_W-1:0] work_ram    [RAM_BYTES];
    logic [DATA_W-1:0] program_rom [ROM_MAX_BYTES];
    bit                rom_loaded  [ROM_MAX_BYTES];
    logic [CFG_W-1:0]  rom_size = '0;

    bus_access_t pending_accesses [$];
    bus_result_t expected_results [$];
    bus_access_t cur_access;
    int          mismatches = 0;
    int          send_gap   = 0;
    int          send_calm  = 0;
    int          recv_stall = 0;
    int          recv_calm  = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic bit rom_hit(input logic [ADDR_W-1:0] addr,
                                   output logic [INDEX_W-1:0] offset);
        logic [ADDR_W-1:0] off;
        off = addr - ROM_BASE;
        if (rom_size == ROM_MIRROR_SIZE) off &= ROM_MIRROR_MASK;
        offset = off[INDEX_W-1:0];
        return addr >= ROM_BASE && rom_size != 0 && off < rom_size;
    endfunction

    function automatic bus_result_t decode_access(bus_access_t acc);
        bus_result_t        r;
        logic [ADDR_W-1:0]  a;
        logic [INDEX_W-1:0] off;
        r = '0;
        a = acc.address;
        case (acc.action)
            ACT_READ: begin
                if (a < RAM_END) begin
                    r.read_data = work_ram[a[RAM_AW-1:0]];
                    r.target    = TGT_RAM;
                end else if (a < PPU_END) begin
                    r.target   = TGT_PPU;
                    r.dev_addr = a & PPU_MASK;
                end else if (a == PAD0_ADDR) begin
                    r.target   = TGT_PAD;
                    r.dev_addr = PAD0_PORT;
                end else if (a == PAD1_ADDR) begin
                    r.target   = TGT_PAD;
                    r.dev_addr = PAD1_PORT;
                end else if (a == APU_STATUS) begin
                    r.target   = TGT_APU;
                    r.dev_addr = a;
                end else if (rom_hit(a, off)) begin
                    r.read_data = program_rom[off];
                    r.target    = TGT_ROM;
                end
            end
            ACT_WRITE: begin
                if (a < RAM_END) begin
                    work_ram[a[RAM_AW-1:0]] = acc.data;
                    r.target = TGT_RAM;
                end else begin
                    r.dev_data = acc.data;
                    r.dev_wr   = 1'b1;
                    if (a < PPU_END) begin
                        r.target   = TGT_PPU;
                        r.dev_addr = a & PPU_MASK;
                    end else if (a == DMA_ADDR) begin
                        r.target   = TGT_DMA;
                        r.dev_addr = a;
                    end else if (a == PAD0_ADDR) begin
                        r.target   = TGT_PAD;
                        r.dev_addr = PAD0_PORT;
                    end else if (a <= APU_LAST || a == APU_STATUS || a == PAD1_ADDR) begin
                        r.target   = TGT_APU;
                        r.dev_addr = a;
                    end else begin
                        r = '0;
                    end
                end
            end
            ACT_LOAD: program_rom[acc.load_index] = acc.data;
            default: ;
        endcase
        return r;
    endfunction

    // Precede any in-bounds ROM read of an unloaded byte with a load of it.
    function automatic void enqueue_access(t_action act, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] data,
                                           logic [INDEX_W-1:0] idx);
        bus_access_t        acc;
        bus_access_t        fill;
        logic [INDEX_W-1:0] off;
        if (act == ACT_READ && rom_hit(addr, off) && !rom_loaded[off]) begin
            fill.action     = ACT_LOAD;
            fill.address    = 16'($urandom);
            fill.data       = 8'($urandom);
            fill.load_index = off;
            rom_loaded[off] = 1'b1;
            pending_accesses.push_back(fill);
        end
        if (act == ACT_LOAD) rom_loaded[idx] = 1'b1;
        acc.action     = act;
        acc.address    = addr;
        acc.data       = data;
        acc.load_index = idx;
        pending_accesses.push_back(acc);
    endfunction

    function automatic void queue_random_traffic(int count);
        int                 kind;
        t_action            act;
        logic [ADDR_W-1:0]  addr;
        logic [INDEX_W-1:0] off;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            act  = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
            addr = 16'($urandom);
            if (kind < 30) begin
                addr = {3'b000, 2'($urandom),
                        ($urandom_range(0, 2) == 0) ? 11'($urandom)
                                                    : 11'($urandom_range(0, 31))};
            end else if (kind < 45) begin
                act = ACT_READ;
                if (rom_size != 0 && $urandom_range(0, 9) < 7) begin
                    off  = INDEX_W'($urandom_range(0, rom_size - 1));
                    addr = ROM_BASE | ADDR_W'(off);
                    if (rom_size == ROM_MIRROR_SIZE && $urandom_range(0, 1)) addr[14] = 1'b1;
                end else begin
                    addr = ROM_BASE | 16'($urandom_range(0, 16'h7FFF));
                end
            end else if (kind < 55) begin
                act = ACT_LOAD;
            end else if (kind < 65) begin
                addr = RAM_END | 16'($urandom_range(0, 16'h1FFF));
            end else if (kind < 82) begin
                addr = ($urandom_range(0, 4) == 0) ? PPU_END | 16'($urandom_range(0, 16'h3FFF))
                                                   : PPU_END | 16'($urandom_range(0, 31));
            end else if (kind >= 95) begin
                act = ACT_NONE;
            end
            enqueue_access(act, addr, 8'($urandom), 15'($urandom));
        end
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic set_rom_size(input logic [CFG_W-1:0] bytes);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bytes;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rom_size     = bytes;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_accesses.size() != 0 || expected_results.size() != 0 || i_s_tvalid);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(decode_access(cur_access));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    cur_access = pending_accesses.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {1'b0, cur_access.load_index, cur_access.data,
                                   cur_access.address};
                    i_s_tuser  <= cur_access.action;
                    if (send_calm > 0) begin
                        send_calm--;
                        send_gap = 0;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no access pending: tdata 0x%0h tuser 0x%0h",
                           o_m_tdata, o_m_tuser);
                    mismatches++;
                end else begin
                    bus_result_t want;
                    want = expected_results.pop_front();
                    compare_field("read_data", 16'(want.read_data), 16'(o_m_tdata[7:0]));
                    compare_field("target", 16'(want.target), 16'(o_m_tuser[2:0]));
                    compare_field("device_address", want.dev_addr, o_m_tdata[23:8]);
                    compare_field("device_data", 16'(want.dev_data), 16'(o_m_tdata[31:24]));
                    compare_field("device_write", 16'(want.dev_wr), 16'(o_m_tuser[3]));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(0, 3) == 0) begin
                    recv_stall = pick_gap();
                end else if ($urandom_range(0, 49) == 0) begin
                    recv_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] phase_sizes [6];
        phase_sizes = '{ROM_MIRROR_SIZE, ROM_LIMIT, 16'd1,
                        16'($urandom_range(2, 32767)), 16'd0, 16'd32767};
        foreach (work_ram[i]) work_ram[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_rom_size(16'd0);
        enqueue_access(ACT_READ,  16'h0000, 8'h00, 15'h0000);
        enqueue_access(ACT_WRITE, 16'h0000, 8'hFF, 15'h7FFF);
        enqueue_access(ACT_READ,  16'h1800, 8'h00, 15'h0000);
        enqueue_access(ACT_WRITE, 16'h1FFF, 8'h81, 15'h0000);
        enqueue_access(ACT_READ,  16'h07FF, 8'h00, 15'h0000);
        enqueue_access(ACT_READ,  16'h2000, 8'h00, 15'h0000);
        enqueue_access(ACT_READ,  16'h3FFF, 8'hFF, 15'h0000);
        enqueue_access(ACT_WRITE, 16'h3FFF, 8'hA5, 15'h0000);
        enqueue_access(ACT_WRITE, DMA_ADDR, 8'h02, 15'h0000);
        enqueue_access(ACT_WRITE, PAD0_ADDR, 8'h01, 15'h0000);
        enqueue_access(ACT_READ,  PAD0_ADDR, 8'h00, 15'h0000);
        enqueue_access(ACT_READ,  PAD1_ADDR, 8'h00, 15'h0000);
        enqueue_access(ACT_WRITE, PAD1_ADDR, 8'h40, 15'h0000);
        enqueue_access(ACT_READ,  APU_STATUS, 8'h00, 15'h0000);
        enqueue_access(ACT_WRITE, APU_STATUS, 8'h0F, 15'h0000);
        enqueue_access(ACT_WRITE, 16'h4000, 8'h30, 15'h0000);
        enqueue_access(ACT_WRITE, APU_LAST, 8'hFF, 15'h0000);
        enqueue_access(ACT_WRITE, 16'h4018, 8'h55, 15'h0000);
        enqueue_access(ACT_READ,  16'h4000, 8'h00, 15'h0000);
        enqueue_access(ACT_READ,  16'h7FFF, 8'h00, 15'h0000);
        enqueue_access(ACT_READ,  ROM_BASE, 8'h00, 15'h0000);
        enqueue_access(ACT_WRITE, 16'hFFFF, 8'h12, 15'h0000);
        enqueue_access(ACT_LOAD,  16'h0000, 8'hC3, 15'h7FFF);
        enqueue_access(ACT_NONE,  16'hFFFF, 8'hFF, 15'h7FFF);
        wait_idle();

        foreach (phase_sizes[i]) begin
            set_rom_size(phase_sizes[i]);
            if (i == 0) begin
                enqueue_access(ACT_LOAD, 16'h0000, 8'h5A, 15'h0000);
                enqueue_access(ACT_LOAD, 16'hFFFF, 8'h99, 15'h3FFF);
                enqueue_access(ACT_READ, ROM_BASE, 8'h00, 15'h0000);
                enqueue_access(ACT_READ, 16'hC000, 8'h00, 15'h0000);
                enqueue_access(ACT_READ, 16'hFFFF, 8'h00, 15'h0000);
                enqueue_access(ACT_READ, 16'hBFFF, 8'h00, 15'h0000);
            end
            queue_random_traffic(155);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
